// File: src/desa_pkg.sv
// Shared types and constants for the double-ended stack allocator.
`timescale 1ns / 1ps
package desa_pkg;

  localparam int FUNC_WIDTH  = 3;
  localparam int ALIGN_WIDTH = 4;
  // widest alignment mask that an exponent of ALIGN_WIDTH bits can ask for
  localparam int MASK_WIDTH  = 2 ** ALIGN_WIDTH - 1;

  typedef enum logic [FUNC_WIDTH-1:0] {
    FUNC_ALLOC_LEFT   = 3'd0,
    FUNC_ALLOC_RIGHT  = 3'd1,
    FUNC_FREE_LEFT    = 3'd2,
    FUNC_FREE_RIGHT   = 3'd3,
    FUNC_RESIZE_LEFT  = 3'd4,
    FUNC_RESIZE_RIGHT = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_NOT_TOP  = 2'd2
  } status_t;

  typedef enum logic {
    CFG_BASE_ADDRESS = 1'b0,
    CFG_CAPACITY     = 1'b1
  } cfg_index_t;

  typedef struct packed {
    status_t status;
    logic    needs_copy;
  } result_flags_t;

endpackage

// File: src/desa_calc.sv
// Combinational evaluation of one allocator request against the current counts.
`timescale 1ns / 1ps
module desa_calc #(
  parameter int ADDR_WIDTH = 32,
  parameter int SIZE_WIDTH = 16
) (
  input  logic [ADDR_WIDTH-1:0]            base_address,
  input  logic [SIZE_WIDTH-1:0]            capacity,
  input  logic [SIZE_WIDTH-1:0]            left_count,
  input  logic [SIZE_WIDTH-1:0]            right_count,
  input  logic [desa_pkg::FUNC_WIDTH-1:0]  func,
  input  logic [ADDR_WIDTH-1:0]            block_address,
  input  logic [SIZE_WIDTH-1:0]            size,
  input  logic [SIZE_WIDTH-1:0]            target_size,
  input  logic [desa_pkg::ALIGN_WIDTH-1:0] align_log2,
  output desa_pkg::result_flags_t          flags,
  output logic [ADDR_WIDTH-1:0]            address,
  output logic [SIZE_WIDTH-1:0]            copy_length,
  output logic [SIZE_WIDTH-1:0]            left_next,
  output logic [SIZE_WIDTH-1:0]            right_next
);
  import desa_pkg::*;

  // room for a count plus a size plus padding plus the other count
  localparam int CW = ((SIZE_WIDTH > MASK_WIDTH) ? SIZE_WIDTH : MASK_WIDTH) + 3;

  logic [MASK_WIDTH-1:0] amask;
  logic [ADDR_WIDTH-1:0] amask_a;
  logic [ADDR_WIDTH-1:0] top_left;
  logic [ADDR_WIDTH-1:0] top_right;
  logic                  is_resize;
  logic                  is_right;
  logic [SIZE_WIDTH-1:0] grab_size;

  logic [ADDR_WIDTH-1:0] neg_start;
  logic [MASK_WIDTH-1:0] pad;
  logic [CW-1:0]         grab_l_count;
  logic                  grab_l_fit;
  logic [ADDR_WIDTH-1:0] grab_l_addr;

  logic [ADDR_WIDTH-1:0] lifted;
  logic [MASK_WIDTH-1:0] slack;
  logic [CW-1:0]         grab_r_count;
  logic                  grab_r_fit;
  logic [ADDR_WIDTH-1:0] grab_r_addr;

  logic                  on_top_left;
  logic                  on_top_right;
  logic                  blk_aligned;
  logic [CW-1:0]         cur;
  logic [CW-1:0]         other;
  logic [CW-1:0]         grown;
  logic                  below_zero;
  logic [CW-1:0]         resize_count;
  logic                  resize_fit;
  logic [SIZE_WIDTH-1:0] min_size;

  assign amask     = ~({MASK_WIDTH{1'b1}} << align_log2);
  assign amask_a   = ADDR_WIDTH'(amask);
  assign top_left  = base_address + ADDR_WIDTH'(left_count);
  assign top_right = base_address + ADDR_WIDTH'(capacity) - ADDR_WIDTH'(right_count);
  assign is_resize = (func == FUNC_RESIZE_LEFT) || (func == FUNC_RESIZE_RIGHT);
  assign is_right  = (func == FUNC_RESIZE_RIGHT);
  assign grab_size = is_resize ? target_size : size;

  // left stack: pad the cursor up to the alignment
  assign neg_start    = '0 - top_left;
  assign pad          = neg_start[MASK_WIDTH-1:0] & amask;
  assign grab_l_count = CW'(left_count) + CW'(grab_size) + CW'(pad);
  assign grab_l_fit   = (grab_l_count + CW'(right_count)) < CW'(capacity);
  assign grab_l_addr  = top_left + ADDR_WIDTH'(pad);

  // right stack: round the new bottom down, the slack joins the block
  assign lifted       = top_right - ADDR_WIDTH'(grab_size);
  assign slack        = lifted[MASK_WIDTH-1:0] & amask;
  assign grab_r_count = CW'(right_count) + CW'(grab_size) + CW'(slack);
  assign grab_r_fit   = (CW'(left_count) + grab_r_count) < CW'(capacity);
  assign grab_r_addr  = lifted & ~amask_a;

  // in-place resize
  assign on_top_left  = (block_address + ADDR_WIDTH'(size)) == top_left;
  assign on_top_right = block_address == top_right;
  assign blk_aligned  = (block_address[MASK_WIDTH-1:0] & amask) == '0;
  assign cur          = is_right ? CW'(right_count) : CW'(left_count);
  assign other        = is_right ? CW'(left_count) : CW'(right_count);
  assign grown        = cur + CW'(target_size);
  assign below_zero   = grown < CW'(size);
  assign resize_count = grown - CW'(size);
  assign resize_fit   = !below_zero && ((resize_count + other) < CW'(capacity));
  assign min_size     = (target_size < size) ? target_size : size;

  always_comb begin
    flags.status     = STATUS_OK;
    flags.needs_copy = 1'b0;
    address          = '0;
    copy_length      = '0;
    left_next        = left_count;
    right_next       = right_count;
    case (func)
      FUNC_ALLOC_LEFT: begin
        if (grab_l_fit) begin
          left_next = SIZE_WIDTH'(grab_l_count);
          address   = grab_l_addr;
        end else begin
          flags.status = STATUS_NO_SPACE;
        end
      end
      FUNC_ALLOC_RIGHT: begin
        if (grab_r_fit) begin
          right_next = SIZE_WIDTH'(grab_r_count);
          address    = grab_r_addr;
        end else begin
          flags.status = STATUS_NO_SPACE;
        end
      end
      FUNC_FREE_LEFT: begin
        if (on_top_left && (size <= left_count)) begin
          left_next = left_count - size;
        end else begin
          flags.status = STATUS_NOT_TOP;
        end
      end
      FUNC_FREE_RIGHT: begin
        if (on_top_right && (size <= right_count)) begin
          right_next = right_count - size;
        end else begin
          flags.status = STATUS_NOT_TOP;
        end
      end
      FUNC_RESIZE_LEFT: begin
        if (on_top_left && blk_aligned) begin
          if (resize_fit) begin
            left_next = SIZE_WIDTH'(resize_count);
            address   = block_address;
          end else begin
            flags.status = STATUS_NO_SPACE;
          end
        end else if (grab_l_fit) begin
          left_next        = SIZE_WIDTH'(grab_l_count);
          address          = grab_l_addr;
          flags.needs_copy = 1'b1;
          copy_length      = min_size;
        end else begin
          flags.status = STATUS_NO_SPACE;
        end
      end
      FUNC_RESIZE_RIGHT: begin
        if (on_top_right && blk_aligned) begin
          if (resize_fit) begin
            right_next = SIZE_WIDTH'(resize_count);
            address    = block_address;
          end else begin
            flags.status = STATUS_NO_SPACE;
          end
        end else if (grab_r_fit) begin
          right_next       = SIZE_WIDTH'(grab_r_count);
          address          = grab_r_addr;
          flags.needs_copy = 1'b1;
          copy_length      = min_size;
        end else begin
          flags.status = STATUS_NO_SPACE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/double_ended_stack_allocator_core.sv
// Top level of the double-ended stack allocator: registers, handshake and config.
`timescale 1ns / 1ps
// Two stacks share the region [base_address, base_address + capacity) and grow
// toward each other; the core keeps only their used byte counts. A request enters
// an input register, is evaluated combinationally against the counts and lands in
// the result register when that register is empty or being drained; with the
// output not stalled one request is taken every cycle. The evaluation stage,
// which reads and updates both count registers, sets that rate. Write base_address
// and capacity only while no request is in flight; both reset to zero, as do the
// counts.
module double_ended_stack_allocator_core #(
  parameter int ADDR_WIDTH = 32,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_enable,
  input  logic                             cfg_index,
  input  logic [((ADDR_WIDTH > SIZE_WIDTH) ? ADDR_WIDTH : SIZE_WIDTH)-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [desa_pkg::FUNC_WIDTH-1:0]  func,
  input  logic [ADDR_WIDTH-1:0]            block_address,
  input  logic [SIZE_WIDTH-1:0]            size,
  input  logic [SIZE_WIDTH-1:0]            target_size,
  input  logic [desa_pkg::ALIGN_WIDTH-1:0] align_log2,
  output logic                             out_valid,
  input  logic                             out_stall,
  output desa_pkg::status_t                status,
  output logic [ADDR_WIDTH-1:0]            address,
  output logic                             needs_copy,
  output logic [SIZE_WIDTH-1:0]            copy_length,
  output logic [SIZE_WIDTH-1:0]            left_used,
  output logic [SIZE_WIDTH-1:0]            right_used
);
  import desa_pkg::*;

  logic [ADDR_WIDTH-1:0]  base_address;
  logic [SIZE_WIDTH-1:0]  capacity;
  logic [SIZE_WIDTH-1:0]  left_count;
  logic [SIZE_WIDTH-1:0]  right_count;

  logic                   req_valid;
  logic [FUNC_WIDTH-1:0]  req_func;
  logic [ADDR_WIDTH-1:0]  req_block_address;
  logic [SIZE_WIDTH-1:0]  req_size;
  logic [SIZE_WIDTH-1:0]  req_target_size;
  logic [ALIGN_WIDTH-1:0] req_align_log2;

  result_flags_t          flags;
  logic [ADDR_WIDTH-1:0]  calc_address;
  logic [SIZE_WIDTH-1:0]  calc_copy_length;
  logic [SIZE_WIDTH-1:0]  left_count_next;
  logic [SIZE_WIDTH-1:0]  right_count_next;

  logic                   advance;
  logic                   in_accept;

  assign advance   = req_valid && (!out_valid || !out_stall);
  assign in_stall  = req_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  desa_calc #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_calc (
    .base_address  (base_address),
    .capacity      (capacity),
    .left_count    (left_count),
    .right_count   (right_count),
    .func          (req_func),
    .block_address (req_block_address),
    .size          (req_size),
    .target_size   (req_target_size),
    .align_log2    (req_align_log2),
    .flags         (flags),
    .address       (calc_address),
    .copy_length   (calc_copy_length),
    .left_next     (left_count_next),
    .right_next    (right_count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      capacity     <= '0;
    end else if (cfg_write_enable) begin
      case (cfg_index_t'(cfg_index))
        CFG_BASE_ADDRESS: base_address <= cfg_data[ADDR_WIDTH-1:0];
        CFG_CAPACITY:     capacity     <= cfg_data[SIZE_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_accept) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_func          <= func;
      req_block_address <= block_address;
      req_size          <= size;
      req_target_size   <= target_size;
      req_align_log2    <= align_log2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
    end else if (advance) begin
      left_count  <= left_count_next;
      right_count <= right_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status      <= flags.status;
      needs_copy  <= flags.needs_copy;
      address     <= calc_address;
      copy_length <= calc_copy_length;
      left_used   <= left_count_next;
      right_used  <= right_count_next;
    end
  end

  a_copy_only_on_success: assert property (@(posedge clk) disable iff (rst)
    (out_valid && needs_copy) |-> (status == STATUS_OK))
    else $error("copy requested on a failed request");

  a_fail_address_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STATUS_OK)) |-> (address == '0))
    else $error("failed request carries an address");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result register can drain");

  a_counts_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(left_count) && $stable(right_count)))
    else $error("stack counts changed without a request");

endmodule
